@@ src/pcnf_pkg.sv @@
package pcnf_pkg;

  // Default sizing handed to the top level.
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 20;

  // Fixed formats.
  localparam int unsigned FracBits  = 8;
  localparam int unsigned RadiusW   = 10;
  localparam int unsigned OutIdxW   = 6;
  localparam int unsigned LimW      = RadiusW + FracBits;
  localparam int unsigned SqW       = 2 * LimW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned PipeDepth = 3;
  localparam int unsigned DrainW    = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CLOSE
  } seq_state_e;

endpackage

@@ src/pairwise_cutoff_neighbor_finder_unit.sv @@
// Channel  Direction  Handshake                Payload
// cfg      in         cfg_we_i                 cfg_wdata_i (cutoff radius)
// in       in         in_valid_i / in_stall_o  start_new_i, pos_x_i, pos_y_i, pos_z_i
// out      out        out_valid_o / out_stall_i is_pair_o, earlier_index_o, new_index_o,
//                                               match_count_o, overflow_o, last_o
//
// Every accepted point that does not find the store full costs MAX_POINTS ring
// steps, then three pipeline drain steps and one closing step; the rotating ring
// of point cells advances one step per cycle while the output does not stall.
// A point that finds the store full skips the ring and the drain and goes
// straight to the closing step. Reset empties the store and clears the cutoff;
// stored coordinates need no reset. An output stall freezes the ring, the
// distance pipeline and the sequencer together, so nothing is lost.
module pairwise_cutoff_neighbor_finder_unit #(
  parameter int unsigned MAX_POINTS = pcnf_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = pcnf_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcnf_pkg::RadiusW-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 start_new_i,
  input  logic signed [COORD_BITS-1:0]         pos_x_i,
  input  logic signed [COORD_BITS-1:0]         pos_y_i,
  input  logic signed [COORD_BITS-1:0]         pos_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_pair_o,
  output logic [pcnf_pkg::OutIdxW-1:0]         earlier_index_o,
  output logic [pcnf_pkg::OutIdxW-1:0]         new_index_o,
  output logic [pcnf_pkg::OutIdxW-1:0]         match_count_o,
  output logic                                 overflow_o,
  output logic                                 last_o
);

  localparam int unsigned IdxW = $clog2(MAX_POINTS);
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PtW  = 3 * COORD_BITS;

  pcnf_pkg::seq_state_e state_q, state_d;

  logic [pcnf_pkg::RadiusW-1:0] cutoff_q;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              matches_q, matches_d;
  logic [IdxW-1:0]              step_q, step_d;
  logic [pcnf_pkg::DrainW-1:0]  drain_q, drain_d;
  logic                         ovf_q, ovf_d;
  logic [PtW-1:0]               probe_q;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic                         is_pair_q;
  logic [IdxW-1:0]              earlier_q;
  logic [CntW-1:0]              new_idx_q;
  logic [CntW-1:0]              match_cnt_q;
  logic                         ovf_out_q;
  logic                         last_q;

  logic in_accept;
  logic en;
  logic shift_en;
  logic issue;
  logic close_load;
  logic last_step;

  logic [PtW-1:0]  ring [MAX_POINTS];
  logic [PtW-1:0]  feed;

  logic            res_valid;
  logic [IdxW-1:0] res_idx;
  logic            res_hit;
  logic            pair_out;

  // The whole datapath advances only when the output register can take data.
  assign en        = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign last_step = (step_q == IdxW'(MAX_POINTS - 1));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
    end else if (cfg_we_i) begin
      cutoff_q <= cfg_wdata_i;
    end
  end

  // Point ring. Cell zero always holds the point whose index equals the
  // current step; after MAX_POINTS steps every point is back in place. The
  // new point enters at the tail on the step that reaches the free slot.
  assign feed = (CntW'(step_q) == count_q) ? probe_q : ring[0];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    logic [PtW-1:0] cell_in;
    if (i == MAX_POINTS - 1) begin : g_tail
      assign cell_in = feed;
    end else begin : g_body
      assign cell_in = ring[i+1];
    end
    pcnf_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_en_i(shift_en),
      .point_i   (cell_in),
      .point_o   (ring[i])
    );
  end

  pcnf_dist #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IdxW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (issue),
    .idx_i   (step_q),
    .stored_i(ring[0]),
    .probe_i (probe_q),
    .cutoff_i(cutoff_q),
    .valid_o (res_valid),
    .idx_o   (res_idx),
    .hit_o   (res_hit)
  );

  assign pair_out = res_valid && res_hit;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcnf_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (!start_new_i && count_q == CntW'(MAX_POINTS)) ?
                    pcnf_pkg::ST_CLOSE : pcnf_pkg::ST_SCAN;
        end
      end
      pcnf_pkg::ST_SCAN: begin
        if (en && last_step) begin
          state_d = pcnf_pkg::ST_DRAIN;
        end
      end
      pcnf_pkg::ST_DRAIN: begin
        if (en && drain_q == pcnf_pkg::DrainW'(pcnf_pkg::PipeDepth - 1)) begin
          state_d = pcnf_pkg::ST_CLOSE;
        end
      end
      pcnf_pkg::ST_CLOSE: begin
        if (en) begin
          state_d = pcnf_pkg::ST_IDLE;
        end
      end
      default: state_d = pcnf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    shift_en   = 1'b0;
    issue      = 1'b0;
    close_load = 1'b0;
    case (state_q)
      pcnf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      pcnf_pkg::ST_SCAN: begin
        shift_en = en;
        issue    = CntW'(step_q) < count_q;
      end
      pcnf_pkg::ST_DRAIN: begin
      end
      pcnf_pkg::ST_CLOSE: begin
        close_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Counters and bookkeeping.
  always_comb begin
    count_d   = count_q;
    matches_d = matches_q;
    step_d    = step_q;
    drain_d   = drain_q;
    ovf_d     = ovf_q;
    if (in_accept) begin
      count_d   = start_new_i ? '0 : count_q;
      ovf_d     = !start_new_i && count_q == CntW'(MAX_POINTS);
      matches_d = '0;
      step_d    = '0;
      drain_d   = '0;
    end else if (en) begin
      if (shift_en) begin
        step_d = step_q + IdxW'(1);
      end
      if (state_q == pcnf_pkg::ST_DRAIN) begin
        drain_d = drain_q + pcnf_pkg::DrainW'(1);
      end
      if (pair_out) begin
        matches_d = matches_q + CntW'(1);
      end
      if (close_load && !ovf_q) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pcnf_pkg::ST_IDLE;
      count_q   <= '0;
      matches_q <= '0;
      step_q    <= '0;
      drain_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      matches_q <= matches_d;
      step_q    <= step_d;
      drain_q   <= drain_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      probe_q <= {pos_z_i, pos_y_i, pos_x_i};
    end
  end

  // Output register: either a pair from the pipeline or the closing transaction.
  assign out_valid_d = en ? (close_load || pair_out) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (close_load) begin
        is_pair_q   <= 1'b0;
        earlier_q   <= '0;
        new_idx_q   <= ovf_q ? '0 : count_q;
        match_cnt_q <= ovf_q ? '0 : matches_q;
        ovf_out_q   <= ovf_q;
        last_q      <= 1'b1;
      end else begin
        is_pair_q   <= 1'b1;
        earlier_q   <= res_idx;
        new_idx_q   <= count_q;
        match_cnt_q <= '0;
        ovf_out_q   <= 1'b0;
        last_q      <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_pair_o       = is_pair_q;
  assign earlier_index_o = pcnf_pkg::OutIdxW'(earlier_q);
  assign new_index_o     = pcnf_pkg::OutIdxW'(new_idx_q);
  assign match_count_o   = pcnf_pkg::OutIdxW'(match_cnt_q);
  assign overflow_o      = ovf_out_q;
  assign last_o          = last_q;

endmodule

@@ src/pcnf_cell.sv @@
// One slot of the rotating point ring.
module pcnf_cell #(
  parameter int unsigned COORD_BITS = pcnf_pkg::CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    shift_en_i,
  input  logic [3*COORD_BITS-1:0] point_i,
  output logic [3*COORD_BITS-1:0] point_o
);

  logic [3*COORD_BITS-1:0] point_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      point_q <= point_i;
    end
  end

  assign point_o = point_q;

endmodule

@@ src/pcnf_dist.sv @@
// Three-stage squared-distance test of one stored point against the new point.
module pcnf_dist #(
  parameter int unsigned COORD_BITS = pcnf_pkg::CoordBitsDef,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic [3*COORD_BITS-1:0]       stored_i,
  input  logic [3*COORD_BITS-1:0]       probe_i,
  input  logic [pcnf_pkg::RadiusW-1:0]  cutoff_i,
  output logic                          valid_o,
  output logic [IDX_W-1:0]              idx_o,
  output logic                          hit_o
);

  localparam int unsigned AbsW = (COORD_BITS > pcnf_pkg::LimW) ? COORD_BITS : pcnf_pkg::LimW;

  logic [pcnf_pkg::LimW-1:0] lim;
  logic [pcnf_pkg::SqW-1:0]  lim_sq_q;
  logic [COORD_BITS-1:0]     abs_v [3];
  logic [2:0]                axis_near;

  logic                      s1_valid_q, s2_valid_q, s3_valid_q;
  logic [IDX_W-1:0]          s1_idx_q, s2_idx_q, s3_idx_q;
  logic                      s1_near_q, s2_near_q, s3_hit_q;
  logic [pcnf_pkg::LimW-1:0] s1_abs_q [3];
  logic [pcnf_pkg::SqW-1:0]  s2_sq_q [3];
  logic [pcnf_pkg::SumW-1:0] sum;

  assign lim = {cutoff_i, {pcnf_pkg::FracBits{1'b0}}};

  // The user changes the limit only while idle (unchecked); no enable needed.
  always_ff @(posedge clk_i) begin
    lim_sq_q <= pcnf_pkg::SqW'(lim) * pcnf_pkg::SqW'(lim);
  end

  always_comb begin
    logic signed [COORD_BITS:0] diff;
    for (int a = 0; a < 3; a++) begin
      diff = {stored_i[a*COORD_BITS+COORD_BITS-1], stored_i[a*COORD_BITS +: COORD_BITS]}
           - {probe_i[a*COORD_BITS+COORD_BITS-1], probe_i[a*COORD_BITS +: COORD_BITS]};
      abs_v[a] = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
      axis_near[a] = AbsW'(abs_v[a]) < AbsW'(lim);
    end
  end

  assign sum = pcnf_pkg::SumW'(s2_sq_q[0]) + pcnf_pkg::SumW'(s2_sq_q[1])
             + pcnf_pkg::SumW'(s2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_idx_q  <= idx_i;
      s1_near_q <= &axis_near;
      for (int a = 0; a < 3; a++) begin
        s1_abs_q[a] <= pcnf_pkg::LimW'(abs_v[a]);
      end
      s2_idx_q  <= s1_idx_q;
      s2_near_q <= s1_near_q;
      for (int a = 0; a < 3; a++) begin
        s2_sq_q[a] <= pcnf_pkg::SqW'(s1_abs_q[a]) * pcnf_pkg::SqW'(s1_abs_q[a]);
      end
      s3_idx_q <= s2_idx_q;
      s3_hit_q <= s2_near_q && (sum < pcnf_pkg::SumW'(lim_sq_q));
    end
  end

  assign valid_o = s3_valid_q;
  assign idx_o   = s3_idx_q;
  assign hit_o   = s3_hit_q;

endmodule
